// ===== src/geo_mask_tile_cache_lookup_top_macros.svh =====
// ----------------------------------------------------------------------------
// Geo mask tile cache lookup assertion macros
// Concurrent assertion wrappers clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GEO_MASK_TILE_CACHE_LOOKUP_TOP_MACROS_SVH
`define GEO_MASK_TILE_CACHE_LOOKUP_TOP_MACROS_SVH

// Invariant or implication checked at every edge.
`define GMTCL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a result in the next.
`define GMTCL_ASSERT_NEXT(name, cond, res, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error(msg);

`endif

// ===== src/gmtcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Geo mask tile cache lookup package
// Widths, constants and codes shared by the lookup block.
// ----------------------------------------------------------------------------
package gmtcl_pkg;

    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_W       = 2;

    localparam int DEFAULT_TILE_SLOTS      = 32;
    localparam int DEFAULT_POINTER_ENTRIES = 65536;
    localparam int TILE_WORDS              = 1024;
    localparam int WORD_W                  = $clog2(TILE_WORDS);

    localparam int COUNT_W = 26;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(5500 * 10000);
    localparam logic [15:0] NO_BOX = 16'hFFFF;

    localparam logic signed [25:0] LAT_SHIFT = 26'sd5898240;
    localparam logic [23:0]        LAT_MAX   = 24'd11796480;
    localparam logic signed [26:0] LON_SHIFT = 27'sd11796480;
    localparam logic [24:0]        LON_MAX   = 25'd23592960;
    localparam logic [7:0]  LAT_IDX_TOP = 8'd179;
    localparam logic [8:0]  LON_IDX_TOP = 9'd359;
    localparam logic [6:0]  SUB_TOP     = 7'd127;
    localparam logic [15:0] BOX_ROW     = 16'd360;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_LOAD  = 2'd1,
        OP_FILL  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_ANSWER    = 3'd0,
        ST_FILL      = 3'd1,
        ST_NOT_READY = 3'd2,
        ST_COUNT     = 3'd3,
        ST_BUSY      = 3'd4
    } status_t;

endpackage

// ===== src/geo_mask_tile_cache_lookup_top.sv =====
// Flow: a query runs S_CALC, S_PTR, S_DEC to the result register for uniform boxes,
// adds S_TILE, S_TBIT on the last-box path, and scans the active slots of the mask
// first otherwise (one slot read per cycle from the slot memory). Pointer loads and
// plain fill words are taken in idle; the last fill word answers via S_TILE, S_TBIT. Input is ready only in idle.
// Reset: asynchronous, active low; counts, slots, fill state and ready bits cleared.
// ----------------------------------------------------------------------------
// Geo mask tile cache lookup
// Point-in-mask query with pointer table, per-mask LRU tile cache and fills.
// ----------------------------------------------------------------------------
module geo_mask_tile_cache_lookup_top #(
    parameter int TILE_SLOTS      = gmtcl_pkg::DEFAULT_TILE_SLOTS,
    parameter int POINTER_ENTRIES = gmtcl_pkg::DEFAULT_POINTER_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // latitude, longitude, entry_index, entry_value, zero fill
    input  logic [gmtcl_pkg::IN_TDATA_W-1:0]   s_tdata,
    // opcode, mask_sel
    input  logic [gmtcl_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // mask_bit, record_number, fill_slot, zero fill
    output logic [gmtcl_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status
    output logic [gmtcl_pkg::OUT_TUSER_W-1:0]  m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gmtcl_pkg::CFG_W-1:0]        cfg_data
);
    import gmtcl_pkg::*;
    `include "geo_mask_tile_cache_lookup_top_macros.svh"

    localparam int SLOT_W  = $clog2(TILE_SLOTS);
    localparam int CNT_W   = $clog2(TILE_SLOTS + 1);
    localparam int GS_W    = $clog2(2 * TILE_SLOTS);
    localparam int TILE_AW = GS_W + WORD_W;
    localparam int PTR_AW  = $clog2(2 * POINTER_ENTRIES);
    localparam int SLOT_DEPTH = 2 * TILE_SLOTS;
    localparam int TILE_DEPTH = 2 * TILE_SLOTS * TILE_WORDS;
    localparam int PTR_DEPTH  = 2 * POINTER_ENTRIES;
    localparam logic [GS_W-1:0]   SLOT_OFS  = GS_W'(TILE_SLOTS);
    localparam logic [PTR_AW-1:0] PTR_OFS   = PTR_AW'(POINTER_ENTRIES);
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(TILE_SLOTS);
    localparam logic [16:0]       PTR_LIM   = 17'(POINTER_ENTRIES);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(TILE_WORDS - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CALC = 8'b0000_0010,
        S_PTR  = 8'b0000_0100,
        S_DEC  = 8'b0000_1000,
        S_SCAN = 8'b0001_0000,
        S_TILE = 8'b0010_0000,
        S_TBIT = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CFG_W-1:0]   mask_ready_reg, mask_ready_next;
    logic [COUNT_W-1:0] acc_cnt_reg [2];
    logic [COUNT_W-1:0] acc_cnt_next [2];
    logic [CNT_W-1:0]   active_reg [2];
    logic [CNT_W-1:0]   active_next [2];
    logic [15:0]        recent_box_reg [2];
    logic [15:0]        recent_box_next [2];
    logic [SLOT_W-1:0]  recent_slot_reg [2];
    logic [SLOT_W-1:0]  recent_slot_next [2];
    logic               fill_pend_reg, fill_pend_next;
    logic               fill_mask_reg, fill_mask_next;
    logic [SLOT_W-1:0]  fill_slot_reg, fill_slot_next;
    logic [WORD_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [13:0]        pend_wb_reg, pend_wb_next;
    logic               out_valid_reg, out_valid_next;

    logic [15:0]        fill_box_reg, fill_box_next;
    logic               mask_reg, mask_next;
    logic signed [23:0] lat_reg, lat_next;
    logic signed [24:0] lon_reg, lon_next;
    logic [15:0]        box_reg, box_next;
    logic [13:0]        wb_reg, wb_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SLOT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [COUNT_W-1:0] low_reg, low_next;
    logic [SLOT_W-1:0]  low_idx_reg, low_idx_next;
    logic               tile_mask_reg, tile_mask_next;
    logic [SLOT_W-1:0]  tile_slot_reg, tile_slot_next;
    status_t            res_status_reg, res_status_next;
    logic               res_bit_reg, res_bit_next;
    logic [15:0]        res_rec_reg, res_rec_next;
    logic [4:0]         res_slot_reg, res_slot_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic [OUT_TUSER_W-1:0] out_tuser_reg, out_tuser_next;

    logic [15:0] ptr_mem [PTR_DEPTH];
    logic [15:0] tile_mem [TILE_DEPTH];
    logic [15:0] slot_box_mem [SLOT_DEPTH];
    logic [COUNT_W-1:0] slot_use_mem [SLOT_DEPTH];

    logic              ptr_we;
    logic [PTR_AW-1:0] ptr_waddr, ptr_raddr;
    logic [15:0]       ptr_q;
    logic               tile_we;
    logic [TILE_AW-1:0] tile_waddr, tile_raddr;
    logic [15:0]        tile_q;
    logic               slot_box_we, slot_use_we;
    logic [GS_W-1:0]    slot_waddr, slot_raddr;
    logic [COUNT_W-1:0] slot_use_wdata;
    logic [15:0]        slot_box_q;
    logic [COUNT_W-1:0] slot_use_q;

    logic               in_accept, cfg_accept;
    op_t                in_op;
    logic               in_mask;
    logic [15:0]        in_index, in_value;
    logic [COUNT_W-1:0] cnt_inc;
    logic signed [25:0] lat_off;
    logic signed [26:0] lon_off;
    logic [23:0]        lat_c;
    logic [24:0]        lon_c;
    logic [7:0]         lat_idx;
    logic [8:0]         lon_idx;
    logic [6:0]         lat_sub, lon_sub;
    logic [CNT_W-1:0]   scan_nxt;
    logic               do_miss;
    logic [SLOT_W-1:0]  miss_slot;
    logic [COUNT_W-1:0] low_eff;
    logic [SLOT_W-1:0]  low_idx_eff;
    logic [CNT_W-1:0]   n_val;

    function automatic logic [GS_W-1:0] gslot(input logic m, input logic [SLOT_W-1:0] idx);
        gslot = ({GS_W{m}} & SLOT_OFS) + GS_W'(idx);
    endfunction

    assign in_accept  = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign in_op      = op_t'(s_tuser[1:0]);
    assign in_mask    = s_tuser[2];
    assign in_index   = s_tdata[64:49];
    assign in_value   = s_tdata[80:65];
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_tdata_reg;
    assign m_tuser    = out_tuser_reg;

    // point to box and word/bit
    always_comb
    begin
        lat_off = $signed({{2{lat_reg[23]}}, lat_reg}) + LAT_SHIFT;
        lon_off = $signed({{2{lon_reg[24]}}, lon_reg}) + LON_SHIFT;
        if (lat_off[25])
        begin
            lat_c = '0;
        end
        else if (lat_off > $signed({2'b00, LAT_MAX}))
        begin
            lat_c = LAT_MAX;
        end
        else
        begin
            lat_c = lat_off[23:0];
        end
        if (lon_off[26])
        begin
            lon_c = '0;
        end
        else if (lon_off > $signed({2'b00, LON_MAX}))
        begin
            lon_c = LON_MAX;
        end
        else
        begin
            lon_c = lon_off[24:0];
        end
        lat_idx = (lat_c == LAT_MAX) ? LAT_IDX_TOP : lat_c[23:16];
        lat_sub = (lat_c == LAT_MAX) ? SUB_TOP : lat_c[15:9];
        lon_idx = (lon_c == LON_MAX) ? LON_IDX_TOP : lon_c[24:16];
        lon_sub = (lon_c == LON_MAX) ? SUB_TOP : lon_c[15:9];
    end

    assign ptr_raddr  = ({PTR_AW{mask_reg}} & PTR_OFS) + PTR_AW'(box_reg);
    assign tile_raddr = {gslot(tile_mask_reg, tile_slot_reg), wb_reg[13:4]};
    assign tile_waddr = {gslot(fill_mask_reg, fill_slot_reg), fill_cnt_reg};
    assign ptr_waddr  = ({PTR_AW{in_mask}} & PTR_OFS) + PTR_AW'(in_index);
    assign scan_nxt   = CNT_W'(cmp_idx_reg) + CNT_W'(1);
    assign slot_raddr = (state_reg == S_SCAN && scan_nxt < n_reg)
                        ? gslot(mask_reg, SLOT_W'(scan_nxt)) : gslot(mask_reg, '0);

    always_comb
    begin
        state_next       = state_reg;
        mask_ready_next  = mask_ready_reg;
        acc_cnt_next     = acc_cnt_reg;
        active_next      = active_reg;
        recent_box_next  = recent_box_reg;
        recent_slot_next = recent_slot_reg;
        fill_pend_next   = fill_pend_reg;
        fill_mask_next   = fill_mask_reg;
        fill_slot_next   = fill_slot_reg;
        fill_cnt_next    = fill_cnt_reg;
        pend_wb_next     = pend_wb_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        fill_box_next    = fill_box_reg;
        mask_next        = mask_reg;
        lat_next         = lat_reg;
        lon_next         = lon_reg;
        box_next         = box_reg;
        wb_next          = wb_reg;
        n_next           = n_reg;
        cmp_idx_next     = cmp_idx_reg;
        low_next         = low_reg;
        low_idx_next     = low_idx_reg;
        tile_mask_next   = tile_mask_reg;
        tile_slot_next   = tile_slot_reg;
        res_status_next  = res_status_reg;
        res_bit_next     = res_bit_reg;
        res_rec_next     = res_rec_reg;
        res_slot_next    = res_slot_reg;
        out_tdata_next   = out_tdata_reg;
        out_tuser_next   = out_tuser_reg;
        ptr_we           = 1'b0;
        tile_we          = 1'b0;
        slot_box_we      = 1'b0;
        slot_use_we      = 1'b0;
        slot_waddr       = gslot(mask_reg, cmp_idx_reg);
        slot_use_wdata   = acc_cnt_reg[mask_reg];
        cnt_inc          = acc_cnt_reg[in_mask];
        do_miss          = 1'b0;
        miss_slot        = '0;
        n_val            = active_reg[mask_reg];
        low_eff          = low_reg;
        low_idx_eff      = low_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_op)
                        OP_QUERY:
                        begin
                            mask_next    = in_mask;
                            lat_next     = $signed(s_tdata[23:0]);
                            lon_next     = $signed(s_tdata[48:24]);
                            res_bit_next = 1'b0;
                            res_rec_next = '0;
                            res_slot_next = '0;
                            if (fill_pend_reg)
                            begin
                                res_status_next = ST_BUSY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                if (cnt_inc < COUNT_LIMIT)
                                begin
                                    cnt_inc = cnt_inc + COUNT_W'(1);
                                end
                                acc_cnt_next[in_mask] = cnt_inc;
                                if (cnt_inc >= COUNT_LIMIT)
                                begin
                                    res_status_next = ST_COUNT;
                                    state_next      = S_EMIT;
                                end
                                else if (!mask_ready_reg[in_mask])
                                begin
                                    res_status_next = ST_NOT_READY;
                                    state_next      = S_EMIT;
                                end
                                else
                                begin
                                    state_next = S_CALC;
                                end
                            end
                        end
                        OP_LOAD:
                        begin
                            ptr_we = ({1'b0, in_index} < PTR_LIM);
                        end
                        OP_FILL:
                        begin
                            if (fill_pend_reg)
                            begin
                                tile_we = 1'b1;
                                if (fill_cnt_reg == LAST_WORD)
                                begin
                                    fill_pend_next = 1'b0;
                                    fill_cnt_next  = '0;
                                    recent_box_next[fill_mask_reg]  = fill_box_reg;
                                    recent_slot_next[fill_mask_reg] = fill_slot_reg;
                                    tile_mask_next = fill_mask_reg;
                                    tile_slot_next = fill_slot_reg;
                                    wb_next        = pend_wb_reg;
                                    state_next     = S_TILE;
                                end
                                else
                                begin
                                    fill_cnt_next = fill_cnt_reg + WORD_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (cfg_accept)
                begin
                    mask_ready_next = cfg_data;
                    for (int m = 0; m < 2; m++)
                    begin
                        if (cfg_data[m])
                        begin
                            acc_cnt_next[m]    = '0;
                            active_next[m]     = '0;
                            recent_box_next[m] = NO_BOX;
                            if (fill_pend_reg && fill_mask_reg == 1'(m))
                            begin
                                fill_pend_next = 1'b0;
                                fill_cnt_next  = '0;
                            end
                        end
                    end
                end
            end
            S_CALC:
            begin
                box_next   = 16'(lon_idx) + 16'(lat_idx) * BOX_ROW;
                wb_next    = {lat_sub, lon_sub};
                state_next = S_PTR;
            end
            S_PTR:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                res_rec_next  = ptr_q;
                res_bit_next  = 1'b0;
                res_slot_next = '0;
                if (ptr_q < 16'd2)
                begin
                    res_status_next = ST_ANSWER;
                    res_bit_next    = ptr_q[0];
                    res_rec_next    = '0;
                    state_next      = S_EMIT;
                end
                else if (box_reg == recent_box_reg[mask_reg])
                begin
                    tile_mask_next = mask_reg;
                    tile_slot_next = recent_slot_reg[mask_reg];
                    state_next     = S_TILE;
                end
                else
                begin
                    n_next       = n_val;
                    cmp_idx_next = '0;
                    low_next     = COUNT_LIMIT;
                    low_idx_next = '0;
                    if (n_val == '0)
                    begin
                        do_miss   = 1'b1;
                        miss_slot = '0;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                n_val = n_reg;
                if (slot_box_q == box_reg)
                begin
                    slot_use_we    = 1'b1;
                    recent_box_next[mask_reg]  = box_reg;
                    recent_slot_next[mask_reg] = cmp_idx_reg;
                    tile_mask_next = mask_reg;
                    tile_slot_next = cmp_idx_reg;
                    state_next     = S_TILE;
                end
                else
                begin
                    if (slot_use_q < low_reg)
                    begin
                        low_eff     = slot_use_q;
                        low_idx_eff = cmp_idx_reg;
                    end
                    low_next     = low_eff;
                    low_idx_next = low_idx_eff;
                    if (scan_nxt == n_reg)
                    begin
                        do_miss   = 1'b1;
                        miss_slot = (n_reg < SLOTS_CNT) ? SLOT_W'(n_reg) : low_idx_eff;
                    end
                    else
                    begin
                        cmp_idx_next = SLOT_W'(scan_nxt);
                    end
                end
            end
            S_TILE:
            begin
                state_next = S_TBIT;
            end
            S_TBIT:
            begin
                res_status_next = ST_ANSWER;
                res_bit_next    = tile_q[4'd15 - wb_reg[3:0]];
                res_rec_next    = '0;
                res_slot_next   = '0;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_tdata_next = {2'b00, res_slot_reg, res_rec_reg, res_bit_reg};
                    out_tuser_next = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // claim a slot and request the tile
        if (do_miss)
        begin
            if (n_val < SLOTS_CNT)
            begin
                active_next[mask_reg] = n_val + CNT_W'(1);
            end
            slot_box_we     = 1'b1;
            slot_use_we     = 1'b1;
            slot_waddr      = gslot(mask_reg, miss_slot);
            fill_pend_next  = 1'b1;
            fill_mask_next  = mask_reg;
            fill_slot_next  = miss_slot;
            fill_cnt_next   = '0;
            fill_box_next   = box_reg;
            pend_wb_next    = wb_reg;
            res_status_next = ST_FILL;
            res_bit_next    = 1'b0;
            res_slot_next   = 5'(miss_slot);
            state_next      = S_EMIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[ptr_waddr] <= in_value;
        end
        ptr_q <= ptr_mem[ptr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tile_we)
        begin
            tile_mem[tile_waddr] <= in_value;
        end
        tile_q <= tile_mem[tile_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_box_we)
        begin
            slot_box_mem[slot_waddr] <= box_reg;
        end
        if (slot_use_we)
        begin
            slot_use_mem[slot_waddr] <= slot_use_wdata;
        end
        slot_box_q <= slot_box_mem[slot_raddr];
        slot_use_q <= slot_use_mem[slot_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mask_ready_reg  <= '0;
            acc_cnt_reg     <= '{default: '0};
            active_reg      <= '{default: '0};
            recent_box_reg  <= '{default: NO_BOX};
            recent_slot_reg <= '{default: '0};
            fill_pend_reg   <= 1'b0;
            fill_mask_reg   <= 1'b0;
            fill_slot_reg   <= '0;
            fill_cnt_reg    <= '0;
            pend_wb_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mask_ready_reg  <= mask_ready_next;
            acc_cnt_reg     <= acc_cnt_next;
            active_reg      <= active_next;
            recent_box_reg  <= recent_box_next;
            recent_slot_reg <= recent_slot_next;
            fill_pend_reg   <= fill_pend_next;
            fill_mask_reg   <= fill_mask_next;
            fill_slot_reg   <= fill_slot_next;
            fill_cnt_reg    <= fill_cnt_next;
            pend_wb_reg     <= pend_wb_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_box_reg   <= fill_box_next;
        mask_reg       <= mask_next;
        lat_reg        <= lat_next;
        lon_reg        <= lon_next;
        box_reg        <= box_next;
        wb_reg         <= wb_next;
        n_reg          <= n_next;
        cmp_idx_reg    <= cmp_idx_next;
        low_reg        <= low_next;
        low_idx_reg    <= low_idx_next;
        tile_mask_reg  <= tile_mask_next;
        tile_slot_reg  <= tile_slot_next;
        res_status_reg <= res_status_next;
        res_bit_reg    <= res_bit_next;
        res_rec_reg    <= res_rec_next;
        res_slot_reg   <= res_slot_next;
        out_tdata_reg  <= out_tdata_next;
        out_tuser_reg  <= out_tuser_next;
    end

    `GMTCL_ASSERT(a_fill_cnt_idle, !fill_pend_reg |-> fill_cnt_reg == '0, "fill count without fill")
    `GMTCL_ASSERT(a_active_bound, active_reg[0] <= SLOTS_CNT && active_reg[1] <= SLOTS_CNT, "active slots overflow")
    `GMTCL_ASSERT(a_count_bound, acc_cnt_reg[0] <= COUNT_LIMIT && acc_cnt_reg[1] <= COUNT_LIMIT, "access count overflow")
    `GMTCL_ASSERT(a_scan_range, state_reg == S_SCAN |-> CNT_W'(cmp_idx_reg) < n_reg, "scan past active slots")
    `GMTCL_ASSERT_NEXT(a_emit_load, state_reg == S_EMIT && (!out_valid_reg || m_tready), out_valid_reg && state_reg == S_IDLE, "result not loaded")

endmodule

// ===== verif/tb_geo_mask_tile_cache_lookup_top.sv =====
// ----------------------------------------------------------------------------
// Geo mask tile cache lookup testbench
// Drives queries, pointer loads and tile fill words into the lookup block
// over the stream ports, with random gaps on both sides. Every result word
// is checked field by field against an in-order queue of answers worked out
// by a cycle-free model of the two masks, their tile caches and the fill.
// A short table of directed rows comes first, then random traffic in
// phases with different mask_ready settings.
// ----------------------------------------------------------------------------
module tb_geo_mask_tile_cache_lookup_top;
    import gmtcl_pkg::*;

    localparam int SLOTS     = DEFAULT_TILE_SLOTS;
    localparam int ENTRIES   = DEFAULT_POINTER_ENTRIES;
    localparam int WDOG_MAX  = 5000;
    localparam int SETTLE    = 60;
    localparam int RAND_OPS  = 750;

    localparam int ROW_WORD = 0;
    localparam int ROW_CFG  = 1;
    localparam int ROW_RUN  = 2;

    localparam int LAT_MIN_V = -8388608;
    localparam int LAT_TOP_V = 8388607;
    localparam int LON_MIN_V = -16777216;
    localparam int LON_TOP_V = 16777215;

    typedef struct {
        status_t     st;
        logic        bitv;
        logic [15:0] rec;
        logic [4:0]  slot;
    } answer_t;

    typedef struct {
        int          kind;
        logic [1:0]  op;
        logic        m;
        int          lat;
        int          lon;
        int          idx;
        int          val;
        bit          chk;
        status_t     st;
        logic        bitv;
        logic [15:0] rec;
        logic [4:0]  slot;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [IN_TUSER_W-1:0]   s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [OUT_TUSER_W-1:0]  m_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data;

    // model state
    logic [15:0] ptr_mem [0:2*ENTRIES-1];
    logic [15:0] tile_mem [0:2*SLOTS*TILE_WORDS-1];
    logic [15:0] slot_tag [0:2*SLOTS-1];
    int unsigned slot_stamp [0:2*SLOTS-1];
    int unsigned used_slots [2];
    int unsigned hit_count [2];
    int unsigned last_box [2];
    int unsigned last_slot [2];
    bit          fill_busy;
    int unsigned fill_tgt;
    int unsigned fill_cnt;
    int unsigned fill_wb;
    logic [1:0]  ready_bits;

    answer_t answers_due [$];
    int      pool [2][$];
    int      errors;
    int      checked;
    int      n_query;
    int      n_fill;
    int      idle_cnt;
    bit      calm;

    geo_mask_tile_cache_lookup_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
        errors++;
    endtask

    function automatic void push_answer(status_t st, logic b, logic [15:0] rec, logic [4:0] sl);
        answer_t a;
        a.st = st;
        a.bitv = b;
        a.rec = rec;
        a.slot = sl;
        answers_due.push_back(a);
    endfunction

    function automatic logic tile_bit(int unsigned sl, int unsigned wb);
        logic [15:0] w;
        w = tile_mem[(sl * TILE_WORDS + ((wb >> 4) & 1023)) % (2 * SLOTS * TILE_WORDS)];
        return w[15 - (wb & 15)];
    endfunction

    function automatic void clear_mask(int m);
        used_slots[m] = 0;
        hit_count[m] = 0;
        last_box[m] = NO_BOX;
        if (fill_busy && fill_tgt / SLOTS == m)
        begin
            fill_busy = 0;
            fill_cnt = 0;
        end
    endfunction

    function automatic void apply_ready(logic [1:0] v);
        ready_bits = v;
        if (v[0])
            clear_mask(0);
        if (v[1])
            clear_mask(1);
    endfunction

    function automatic void lookup_point(int m, logic signed [23:0] lat, logic signed [24:0] lon);
        int          lat_off;
        int          lon_off;
        int unsigned lat_i;
        int unsigned lon_i;
        int unsigned lat_s;
        int unsigned lon_s;
        int unsigned box;
        int unsigned wb;
        int unsigned ptr;
        int unsigned base;
        int unsigned low;
        int unsigned low_i;
        int unsigned n;
        int unsigned sl;
        lat_off = int'(lat) + int'(LAT_SHIFT);
        lon_off = int'(lon) + int'(LON_SHIFT);
        if (lat_off < 0) lat_off = 0;
        if (lat_off > int'(LAT_MAX)) lat_off = int'(LAT_MAX);
        if (lon_off < 0) lon_off = 0;
        if (lon_off > int'(LON_MAX)) lon_off = int'(LON_MAX);
        lat_i = (lat_off == int'(LAT_MAX)) ? 179 : lat_off >> 16;
        lon_i = (lon_off == int'(LON_MAX)) ? 359 : lon_off >> 16;
        lat_s = (lat_off == int'(LAT_MAX)) ? 127 : (lat_off >> 9) & 127;
        lon_s = (lon_off == int'(LON_MAX)) ? 127 : (lon_off >> 9) & 127;
        box = lon_i + 360 * lat_i;
        wb = (((lon_s >> 4) + lat_s * 8) << 4) | (lon_s & 15);
        ptr = (box < ENTRIES) ? ptr_mem[m * ENTRIES + box] : 0;
        if (ptr < 2)
        begin
            push_answer(ST_ANSWER, ptr[0], 16'd0, 5'd0);
            return;
        end
        base = m * SLOTS;
        if (box == last_box[m])
        begin
            push_answer(ST_ANSWER, tile_bit(base + last_slot[m] % SLOTS, wb), 16'd0, 5'd0);
            return;
        end
        low = COUNT_LIMIT;
        low_i = 0;
        n = (used_slots[m] > SLOTS) ? SLOTS : used_slots[m];
        for (int unsigned i = 0; i < n; i++)
        begin
            if (slot_tag[base + i] == box[15:0])
            begin
                slot_stamp[base + i] = hit_count[m];
                last_box[m] = box;
                last_slot[m] = i;
                push_answer(ST_ANSWER, tile_bit(base + i, wb), 16'd0, 5'd0);
                return;
            end
            if (slot_stamp[base + i] < low)
            begin
                low = slot_stamp[base + i];
                low_i = i;
            end
        end
        if (n < SLOTS)
        begin
            sl = n;
            used_slots[m] = n + 1;
        end
        else
            sl = low_i;
        slot_tag[base + sl] = box[15:0];
        slot_stamp[base + sl] = hit_count[m];
        fill_busy = 1;
        fill_tgt = base + sl;
        fill_cnt = 0;
        fill_wb = wb;
        push_answer(ST_FILL, 1'b0, ptr[15:0], sl[4:0]);
    endfunction

    function automatic void predict_word(logic [1:0] op, logic m, logic signed [23:0] lat,
                                         logic signed [24:0] lon, logic [15:0] idx,
                                         logic [15:0] val);
        int unsigned t;
        if (op == OP_QUERY)
        begin
            if (fill_busy)
                push_answer(ST_BUSY, 1'b0, 16'd0, 5'd0);
            else
            begin
                if (hit_count[m] < COUNT_LIMIT)
                    hit_count[m]++;
                if (hit_count[m] >= COUNT_LIMIT)
                    push_answer(ST_COUNT, 1'b0, 16'd0, 5'd0);
                else if (!ready_bits[m])
                    push_answer(ST_NOT_READY, 1'b0, 16'd0, 5'd0);
                else
                    lookup_point(m, lat, lon);
            end
        end
        else if (op == OP_LOAD)
        begin
            if (idx < ENTRIES)
                ptr_mem[m * ENTRIES + idx] = val;
        end
        else if (op == OP_FILL && fill_busy)
        begin
            t = fill_tgt % (2 * SLOTS);
            tile_mem[t * TILE_WORDS + fill_cnt % TILE_WORDS] = val;
            fill_cnt++;
            if (fill_cnt >= TILE_WORDS)
            begin
                fill_busy = 0;
                fill_cnt = 0;
                last_box[t / SLOTS] = slot_tag[t];
                last_slot[t / SLOTS] = t % SLOTS;
                push_answer(ST_ANSWER, tile_bit(t, fill_wb), 16'd0, 5'd0);
            end
        end
    endfunction

    task automatic send_word(logic [1:0] op, logic m, int lat, int lon, int idx, int val);
        logic signed [23:0] la;
        logic signed [24:0] lo;
        la = lat[23:0];
        lo = lon[24:0];
        while (!calm && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, val[15:0], idx[15:0], lo, la};
        s_tuser <= {m, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_QUERY)
            n_query++;
        if (op == OP_FILL)
            n_fill++;
        predict_word(op, m, la, lo, idx[15:0], val[15:0]);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_ready(logic [1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_ready(v);
    endtask

    task automatic fill_run;
        for (int i = 0; i < TILE_WORDS; i++)
            send_word(OP_FILL, $urandom_range(1), 0, 0, $urandom_range(65535),
                      $urandom_range(65535));
    endtask

    task automatic noise_query(logic m);
        send_word(OP_QUERY, m, $urandom, $urandom, $urandom_range(65535), $urandom_range(65535));
    endtask

    task automatic point_query(logic m);
        int box;
        int li;
        int lo;
        int lat;
        int lon;
        box = pool[m][$urandom_range(pool[m].size() - 1)];
        li = box / 360;
        lo = box % 360;
        lat = li * 65536 + $urandom_range(65535) - int'(LAT_SHIFT);
        lon = lo * 65536 + $urandom_range(65535) - int'(LON_SHIFT);
        if (li == 179 && $urandom_range(3) == 0)
            lat = $urandom_range(LAT_TOP_V, int'(LAT_SHIFT));
        if (li == 0 && $urandom_range(3) == 0)
            lat = -int'($urandom_range(8388608, int'(LAT_SHIFT)));
        if (lo == 359 && $urandom_range(3) == 0)
            lon = $urandom_range(LON_TOP_V, int'(LON_SHIFT));
        if (lo == 0 && $urandom_range(3) == 0)
            lon = -int'($urandom_range(16777216, int'(LON_SHIFT)));
        send_word(OP_QUERY, m, lat, lon, $urandom_range(65535), $urandom_range(65535));
    endtask

    function automatic int pick_ptr;
        if ($urandom_range(4) == 0)
            return $urandom_range(1);
        return $urandom_range(65535, 2);
    endfunction

    task automatic seed_pool;
        int b;
        for (int m = 0; m < 2; m++)
        begin
            pool[m] = '{0, 359, 64440, 64799};
            for (int i = 0; i < 36; i++)
                pool[m].push_back($urandom_range(64799));
            for (int i = 0; i < pool[m].size(); i++)
            begin
                b = pool[m][i];
                send_word(OP_LOAD, m, $urandom, $urandom, b, pick_ptr());
            end
        end
    endtask

    task automatic random_step(ref int ops);
        int r;
        int m;
        r = $urandom_range(99);
        m = $urandom_range(1);
        if (fill_busy)
        begin
            if (r < 92)
                send_word(OP_FILL, m, $urandom, $urandom, $urandom_range(65535),
                          $urandom_range(65535));
            else
            begin
                ops++;
                if (r < 95)
                    noise_query(m);
                else if (r < 98)
                    send_word(OP_LOAD, m, $urandom, $urandom, $urandom_range(65535),
                              $urandom_range(65535));
                else
                    send_word(2'd3, m, $urandom, $urandom, $urandom_range(65535),
                              $urandom_range(65535));
            end
            return;
        end
        ops++;
        if (r < 70)
        begin
            if (ready_bits[m])
                point_query(m);
            else
                noise_query(m);
        end
        else if (r < 80)
            send_word(OP_LOAD, m, $urandom, $urandom,
                      pool[m][$urandom_range(pool[m].size() - 1)], pick_ptr());
        else if (r < 88)
            send_word(OP_LOAD, m, $urandom, $urandom, $urandom_range(65535),
                      $urandom_range(65535));
        else if (r < 93)
            send_word(2'd3, m, $urandom, $urandom, $urandom_range(65535), $urandom_range(65535));
        else
            send_word(OP_FILL, m, $urandom, $urandom, $urandom_range(65535),
                      $urandom_range(65535));
    endtask

    // result checker, stall generator and watchdog
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n)
        begin
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_MAX)
            begin
                $display("watchdog: no progress for %0d cycles", WDOG_MAX);
                $display("[geo_mask_tile_cache_lookup_top] ERROR");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                    report("unexpected result, status", m_tuser, -1);
                else
                begin
                    a = answers_due.pop_front();
                    if (m_tuser !== a.st)
                        report("status", m_tuser, a.st);
                    if (m_tdata[0] !== a.bitv)
                        report("mask_bit", m_tdata[0], a.bitv);
                    if (m_tdata[16:1] !== a.rec)
                        report("record_number", m_tdata[16:1], a.rec);
                    if (m_tdata[21:17] !== a.slot)
                        report("fill_slot", m_tdata[21:17], a.slot);
                end
                checked++;
            end
        end
    end

    initial
    begin
        row_t rows [$];
        row_t rw;
        int   ops;
        int   b100_lat;
        int   b100_lon;
        logic [1:0] phase_cfg [4];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        checked = 0;
        n_query = 0;
        n_fill = 0;
        idle_cnt = 0;
        calm = 0;
        for (int i = 0; i < 2 * ENTRIES; i++)
            ptr_mem[i] = '0;
        for (int i = 0; i < 2 * SLOTS * TILE_WORDS; i++)
            tile_mem[i] = '0;
        for (int i = 0; i < 2 * SLOTS; i++)
        begin
            slot_tag[i] = '0;
            slot_stamp[i] = 0;
        end
        used_slots = '{0, 0};
        hit_count = '{0, 0};
        last_box = '{NO_BOX, NO_BOX};
        last_slot = '{0, 0};
        fill_busy = 0;
        fill_tgt = 0;
        fill_cnt = 0;
        fill_wb = 0;
        ready_bits = '0;
        phase_cfg = '{2'd3, 2'd1, 2'd2, 2'd3};
        b100_lat = 1000 - int'(LAT_SHIFT);
        b100_lon = 100 * 65536 + 5000 - int'(LON_SHIFT);

        rows = '{
            '{ROW_CFG,  OP_QUERY, 0, 0, 0, 0, 0, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 0, 0, 0, 0, 0, 1, ST_NOT_READY, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 1, LAT_TOP_V, LON_MIN_V, 0, 0, 1, ST_NOT_READY, 0, 0, 0},
            '{ROW_CFG,  OP_QUERY, 0, 0, 0, 0, 3, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_LOAD, 0, 0, 0, 0, 1, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_LOAD, 0, 0, 0, 64799, 0, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_LOAD, 1, 0, 0, 0, 0, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_LOAD, 1, 0, 0, 64799, 1, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_LOAD, 0, 0, 0, 65535, 65535, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 0, LAT_MIN_V, LON_MIN_V, 0, 0, 1, ST_ANSWER, 1, 0, 0},
            '{ROW_WORD, OP_QUERY, 0, LAT_TOP_V, LON_TOP_V, 0, 0, 1, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 1, LAT_MIN_V, LON_MIN_V, 0, 0, 1, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 1, LAT_TOP_V, LON_TOP_V, 0, 0, 1, ST_ANSWER, 1, 0, 0},
            '{ROW_WORD, 2'd3, 1, -1, -1, 65535, 65535, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_FILL, 1, 0, 0, 0, 65535, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_LOAD, 0, 0, 0, 100, 16'h1234, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 0, b100_lat, b100_lon, 0, 0, 1, ST_FILL, 0, 16'h1234, 0},
            '{ROW_RUN,  OP_FILL, 0, 0, 0, 0, 0, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 0, b100_lat + 300, b100_lon + 40000, 0, 0, 0,
              ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_LOAD, 0, 0, 0, 101, 16'hFFFE, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 0, b100_lat, b100_lon + 65536, 0, 0, 1,
              ST_FILL, 0, 16'hFFFE, 1},
            '{ROW_WORD, OP_QUERY, 1, LAT_TOP_V, LON_TOP_V, 0, 0, 1, ST_BUSY, 0, 0, 0},
            '{ROW_CFG,  OP_QUERY, 0, 0, 0, 0, 1, 0, ST_ANSWER, 0, 0, 0},
            '{ROW_WORD, OP_QUERY, 1, 0, 0, 0, 0, 1, ST_NOT_READY, 0, 0, 0},
            '{ROW_CFG,  OP_QUERY, 0, 0, 0, 0, 3, 0, ST_ANSWER, 0, 0, 0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.kind == ROW_CFG)
                write_ready(rw.val[1:0]);
            else if (rw.kind == ROW_RUN)
                fill_run();
            else
            begin
                send_word(rw.op, rw.m, rw.lat, rw.lon, rw.idx, rw.val);
                if (rw.chk)
                begin
                    void'(answers_due.pop_back());
                    push_answer(rw.st, rw.bitv, rw.rec, rw.slot);
                end
            end
        end

        ops = 0;
        for (int p = 0; p < 4; p++)
        begin
            write_ready(phase_cfg[p]);
            if (p == 0)
                seed_pool();
            while (ops < (p + 1) * RAND_OPS / 4)
            begin
                calm = (ops >= 300 && ops < 420);
                random_step(ops);
            end
        end
        calm = 0;
        drain();

        $display("covered %0d queries and %0d fill words, %0d results checked",
                 n_query, n_fill, checked);
        if (errors == 0)
            $display("[geo_mask_tile_cache_lookup_top] OK");
        else
            $display("[geo_mask_tile_cache_lookup_top] ERROR");
        $finish;
    end

endmodule
